/* rtl/cicgd_pkg.sv */
// Package for the cloud-in-cell grid deposit block.
// Holds grid constants, the controller command and status structs and state codes.
// It depends on nothing.
package cicgd_pkg;

  localparam int GRID_SIZE = 64;
  localparam int FRAC_BITS = 16;
  localparam int POS_W = 22;
  localparam int INT_W = POS_W - FRAC_BITS;
  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam longint GRID_CELLS = longint'(GRID_SIZE) * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int CELL_W = 32;
  localparam int PW_W = 32;
  localparam int F_W = FRAC_BITS + 1;
  localparam int W_W = 33;
  localparam int SUM_W = 34;
  localparam logic [CELL_W-1:0] CELL_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [PW_W-1:0] WEIGHT_ONE = 32'h0001_0000;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_WY    = 8'b0000_0100,
    ST_WXY   = 8'b0000_1000,
    ST_WZ    = 8'b0001_0000,
    ST_UPD   = 8'b0010_0000,
    ST_RD    = 8'b0100_0000,
    ST_RDOUT = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic       clear_wr;
    logic       load;
    logic       mul_y;
    logic       mul_xy;
    logic       mul_z;
    logic       upd;
    logic       rd_issue;
    logic       out_rd;
    logic       out_dep;
    logic [2:0] corner;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_read;
  } status_t;

endpackage

/* rtl/cicgd_ctrl.sv */
// Controller state machine for the cloud-in-cell grid deposit block.
// Sequences the clearing pass, the eight corner updates and reads; uses cicgd_pkg.
module cicgd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cicgd_pkg::status_t status,
  output cicgd_pkg::cmd_t   cmd,
  output logic              busy
);
  import cicgd_pkg::*;

  state_t     state, state_next;
  logic [2:0] corner, corner_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      corner <= 3'd0;
    end else begin
      state <= state_next;
      corner <= corner_next;
    end
  end

  always_comb begin
    state_next = state;
    corner_next = corner;
    cmd = '0;
    cmd.corner = corner;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          corner_next = 3'd0;
          state_next = status.op_read ? ST_RD : ST_WY;
        end
      end
      ST_WY: begin
        cmd.mul_y = 1'b1;
        state_next = ST_WXY;
      end
      ST_WXY: begin
        cmd.mul_xy = 1'b1;
        state_next = ST_WZ;
      end
      ST_WZ: begin
        cmd.mul_z = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        corner_next = corner + 3'd1;
        if (corner == 3'd7) begin
          cmd.out_dep = 1'b1;
          state_next = ST_IDLE;
        end else if (!corner[0]) begin
          state_next = ST_WZ;
        end else begin
          state_next = ST_WY;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next = ST_RDOUT;
      end
      ST_RDOUT: begin
        cmd.out_rd = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

/* rtl/cicgd_datapath.sv */
// Datapath for the cloud-in-cell grid deposit block: weight register, item
// registers, weight multipliers, grid memory and result registers; uses cicgd_pkg.
module cicgd_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  cicgd_pkg::cmd_t                 cmd,
  output cicgd_pkg::status_t              status,
  input  logic                            cfg_valid,
  input  logic [cicgd_pkg::PW_W-1:0]      cfg_data,
  input  logic                            operation,
  input  logic [cicgd_pkg::POS_W-1:0]     pos_x,
  input  logic [cicgd_pkg::POS_W-1:0]     pos_y,
  input  logic [cicgd_pkg::POS_W-1:0]     pos_z,
  input  logic [17:0]                     cell_index,
  output logic                            done,
  output logic signed [cicgd_pkg::CELL_W-1:0] cell_value,
  output logic                            saturated
);
  import cicgd_pkg::*;

  localparam logic [F_W-1:0] ONE = F_W'(1) << FRAC_BITS;
  localparam int PY_W = PW_W + F_W + 1;
  localparam int PX_W = W_W + F_W + 1;
  localparam logic [PY_W-1:0] HALF_Y = PY_W'(1) << (FRAC_BITS - 1);
  localparam logic [PX_W-1:0] HALF_X = PX_W'(1) << (FRAC_BITS - 1);

  logic [CELL_W-1:0] mem [GRID_CELLS];
  logic [CELL_W-1:0] q;
  logic [ADDR_W-1:0] clr_addr;

  logic [PW_W-1:0]  particle_weight;
  logic [POS_W-1:0] px, py, pz;
  logic [17:0]      rd_index;
  logic [W_W-1:0]   wy, wxy, w;
  logic             sat_acc;
  logic [ADDR_W-1:0] upd_addr;

  logic [IDX_W-1:0] cx, nx, cy, ny, cz, nz, sx, sy, sz;
  logic [F_W-1:0]   dx, dy, dz, fx, fy, fz;
  logic [PY_W-1:0]  prod_y;
  logic [PX_W-1:0]  prod_xy, prod_z;
  logic [ADDR_W-1:0] corner_addr;
  logic signed [SUM_W-1:0] sum;
  logic [CELL_W-1:0] sum_clip;
  logic             clip;
  logic             rd_in_range;

  function automatic logic [IDX_W-1:0] cell_of(input logic [POS_W-1:0] p);
    logic [INT_W-1:0] c;
    c = p[POS_W-1:FRAC_BITS];
    if (longint'(c) >= longint'(GRID_SIZE)) return '0;
    return IDX_W'(c);
  endfunction

  function automatic logic [IDX_W-1:0] next_of(input logic [IDX_W-1:0] c);
    if (longint'(c) + 1 >= longint'(GRID_SIZE)) return '0;
    return c + IDX_W'(1);
  endfunction

  always_comb begin
    cx = cell_of(px);
    cy = cell_of(py);
    cz = cell_of(pz);
    nx = next_of(cx);
    ny = next_of(cy);
    nz = next_of(cz);
    dx = {1'b0, px[FRAC_BITS-1:0]};
    dy = {1'b0, py[FRAC_BITS-1:0]};
    dz = {1'b0, pz[FRAC_BITS-1:0]};
    fx = cmd.corner[2] ? dx : ONE - dx;
    fy = cmd.corner[1] ? dy : ONE - dy;
    fz = cmd.corner[0] ? dz : ONE - dz;
    sx = cmd.corner[2] ? nx : cx;
    sy = cmd.corner[1] ? ny : cy;
    sz = cmd.corner[0] ? nz : cz;
    corner_addr = ADDR_W'((longint'(sx) * GRID_SIZE + longint'(sy)) * GRID_SIZE
                          + longint'(sz));
    prod_y = PY_W'(fy) * PY_W'(particle_weight) + HALF_Y;
    prod_xy = PX_W'(fx) * PX_W'(wy) + HALF_X;
    prod_z = PX_W'(fz) * PX_W'(wxy) + HALF_X;
    sum = SUM_W'(signed'(q)) + signed'(SUM_W'(w));
    clip = 1'b0;
    sum_clip = sum[CELL_W-1:0];
    if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
      sum_clip = 32'h7FFF_FFFF;
      clip = 1'b1;
    end else if (sum < -(SUM_W'(64'sh8000_0000))) begin
      sum_clip = 32'h8000_0000;
      clip = 1'b1;
    end
    rd_in_range = longint'(rd_index) < GRID_CELLS;
  end

  assign status.clear_last = (longint'(clr_addr) == GRID_CELLS - 1);
  assign status.op_read = operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_weight <= WEIGHT_ONE;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      if (cfg_valid) particle_weight <= cfg_data;
      if (cmd.clear_wr) clr_addr <= clr_addr + ADDR_W'(1);
      done <= cmd.out_rd | cmd.out_dep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      rd_index <= cell_index;
      sat_acc <= 1'b0;
    end
    if (cmd.mul_y) wy <= prod_y[FRAC_BITS +: W_W];
    if (cmd.mul_xy) wxy <= prod_xy[FRAC_BITS +: W_W];
    if (cmd.mul_z) begin
      w <= prod_z[FRAC_BITS +: W_W];
      upd_addr <= corner_addr;
    end
    if (cmd.upd) sat_acc <= sat_acc | clip;
    if (cmd.out_dep) begin
      cell_value <= '0;
      saturated <= sat_acc | clip;
    end
    if (cmd.out_rd) begin
      cell_value <= rd_in_range ? signed'(q) : '0;
      saturated <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) mem[clr_addr] <= CELL_MINUS_ONE;
    else if (cmd.upd) mem[upd_addr] <= sum_clip;
    if (cmd.rd_issue) q <= mem[ADDR_W'(rd_index)];
    else q <= mem[corner_addr];
  end

endmodule

/* rtl/cloud_in_cell_grid_deposit.sv */
// Top level of the cloud-in-cell grid deposit block.
// Joins cicgd_ctrl and cicgd_datapath; uses cicgd_pkg.
//
// After reset the block clears its 64x64x64 grid to -1.0 with one cell per cycle,
// with busy high; configuration writes are taken throughout. In a deposit,
// each of the eight corners is one read-modify-write of the single grid memory,
// after the weight multiply chain. The result is shown for exactly one cycle
// with done high, and the receiver cannot stall it.
module cloud_in_cell_grid_deposit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [cicgd_pkg::POS_W-1:0]         pos_x,
  input  logic [cicgd_pkg::POS_W-1:0]         pos_y,
  input  logic [cicgd_pkg::POS_W-1:0]         pos_z,
  input  logic [17:0]                         cell_index,
  output logic                                done,
  output logic signed [cicgd_pkg::CELL_W-1:0] cell_value,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cicgd_pkg::PW_W-1:0]          cfg_data
);
  import cicgd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cicgd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .busy(busy)
  );

  cicgd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .operation(operation), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cell_index(cell_index), .done(done), .cell_value(cell_value),
    .saturated(saturated)
  );

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_reset_clear: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("clearing pass not started after reset");
`endif

endmodule

/* verif/cloud_in_cell_grid_deposit_test.sv */
// Testbench for cloud_in_cell_grid_deposit: deposits and reads on the density grid,
// predicted cell by cell and checked against every done strobe.
// Depends on cicgd_pkg and the cloud_in_cell_grid_deposit RTL.
`timescale 1ns / 1ps

module cloud_in_cell_grid_deposit_test;
  import cicgd_pkg::*;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int RUN_LIMIT = 2_000_000;

  typedef struct {
    logic signed [CELL_W-1:0] value;
    logic sat;
  } cell_result_t;

  class deposit_scoreboard;
    int grid [0:262143];
    logic [PW_W-1:0] weight;
    cell_result_t pending[$];
    int touched[$];
    int errors;

    function new();
      for (int i = 0; i < 262144; i++) grid[i] = -65536;
      weight = WEIGHT_ONE;
      errors = 0;
    endfunction

    function longint unsigned rnd(longint unsigned v);
      return (v + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    function void note_item(logic op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                            logic [POS_W-1:0] pz, logic [17:0] idx);
      cell_result_t r;
      logic [IDX_W-1:0] ix[2], iy[2], iz[2];
      longint unsigned fx[2], fy[2], fz[2], wy, wxy, w;
      longint sum;
      int addr;
      r.value = 0;
      r.sat = 1'b0;
      if (op == OP_READ) begin
        r.value = grid[idx];
      end else begin
        ix[0] = px[POS_W-1:FRAC_BITS]; ix[1] = ix[0] + IDX_W'(1);
        iy[0] = py[POS_W-1:FRAC_BITS]; iy[1] = iy[0] + IDX_W'(1);
        iz[0] = pz[POS_W-1:FRAC_BITS]; iz[1] = iz[0] + IDX_W'(1);
        fx[1] = 64'(px[FRAC_BITS-1:0]); fx[0] = 65536 - fx[1];
        fy[1] = 64'(py[FRAC_BITS-1:0]); fy[0] = 65536 - fy[1];
        fz[1] = 64'(pz[FRAC_BITS-1:0]); fz[0] = 65536 - fz[1];
        for (int a = 0; a < 2; a++) begin
          for (int b = 0; b < 2; b++) begin
            wy = rnd(fy[b] * longint'(weight));
            wxy = rnd(fx[a] * wy);
            for (int c = 0; c < 2; c++) begin
              w = rnd(fz[c] * wxy);
              addr = int'({ix[a], iy[b], iz[c]});
              sum = longint'(grid[addr]) + longint'(w);
              if (sum > 64'sd2147483647) begin
                sum = 64'sd2147483647;
                r.sat = 1'b1;
              end
              grid[addr] = int'(sum);
              if (touched.size() < 256) touched.push_back(addr);
              else touched[$urandom_range(0, 255)] = addr;
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [CELL_W-1:0] value, logic sat);
      cell_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result cell_value=%0d saturated=%0b", $time, value, sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
        $display("%0t: cell_value expected %0d actual %0d", $time, e.value, value);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = OP_DEPOSIT;
  logic [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [17:0] cell_index = '0;
  logic done;
  logic signed [CELL_W-1:0] cell_value;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [PW_W-1:0] cfg_data = '0;

  deposit_scoreboard board = new();
  int cycles = 0;
  bit idle_on = 1'b1;

  cloud_in_cell_grid_deposit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .cell_index(cell_index),
    .done(done), .cell_value(cell_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(cell_value, saturated);
  end

  task automatic send_item(logic op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                           logic [POS_W-1:0] pz, logic [17:0] idx);
    start <= 1'b1;
    operation <= op;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    cell_index <= idx;
    do @(posedge clk); while (busy);
    board.note_item(op, px, py, pz, idx);
  endtask

  task automatic pause_sender();
    int r, n;
    r = $urandom_range(0, 99);
    n = 0;
    if (idle_on) begin
      if (r >= 90) n = $urandom_range(10, 60);
      else if (r >= 50) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic deposit(logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
    send_item(OP_DEPOSIT, px, py, pz, 18'($urandom()));
    pause_sender();
  endtask

  task automatic read_cell(logic [17:0] idx);
    send_item(OP_READ, POS_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()), idx);
    pause_sender();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_weight(logic [PW_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.weight = v;
    cfg_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    logic [5:0] cells[4] = '{6'd0, 6'd1, 6'd62, 6'd63};
    if ($urandom_range(0, 99) < 40) return POS_W'($urandom_range(0, 22'h3FFFFF));
    return {cells[$urandom_range(0, 3)], 16'($urandom())};
  endfunction

  task automatic random_phase(logic [PW_W-1:0] w, int count);
    drain();
    write_weight(w);
    idle_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        deposit(pick_pos(), pick_pos(), pick_pos());
      end else if ($urandom_range(0, 99) < 70 && board.touched.size() > 0) begin
        read_cell(18'(board.touched[$urandom_range(0, board.touched.size() - 1)]));
      end else begin
        read_cell(18'($urandom_range(0, 262143)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_weight(WEIGHT_ONE);

    deposit(22'h000000, 22'h000000, 22'h000000);
    deposit(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
    deposit(22'h3F8000, 22'h008000, 22'h3FFFFF);
    deposit(22'h010001, 22'h00FFFF, 22'h000001);
    read_cell(18'd0);
    read_cell(18'd1);
    read_cell(18'd4096);
    read_cell(18'd262143);
    read_cell(18'h3F03F);
    read_cell(18'd12345);
    drain();
    write_weight(32'hFFFF_FFFF);
    deposit(22'h050000, 22'h050000, 22'h050000);
    deposit(22'h050000, 22'h050000, 22'h050000);
    read_cell({6'd5, 6'd5, 6'd5});
    read_cell({6'd5, 6'd5, 6'd6});
    drain();
    write_weight(32'd0);
    deposit(22'h07ABCD, 22'h3F1234, 22'h00FFFF);
    read_cell({6'd7, 6'd63, 6'd0});
    drain();
    write_weight(32'd1);
    deposit(22'h08FFFF, 22'h080001, 22'h088000);
    read_cell({6'd8, 6'd8, 6'd8});
    read_cell({6'd9, 6'd8, 6'd9});

    random_phase(WEIGHT_ONE, 100);
    random_phase(32'd1, 100);
    random_phase(32'd0, 60);
    random_phase($urandom(), 100);
    random_phase($urandom_range(0, 32'h0004_0000), 140);
    random_phase(32'hFFFF_FFFF, 100);

    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cicgd_pkg.sv
rtl/cicgd_ctrl.sv
rtl/cicgd_datapath.sv
rtl/cloud_in_cell_grid_deposit.sv
verif/cloud_in_cell_grid_deposit_test.sv
